// ----- hdl/rsamx_pkg.sv -----
// Shared types and constants for the modular exponentiation engine.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package rsamx_pkg;

    localparam int WORD_W   = 16;   // modulus, exponent and residue width
    localparam int CFG_IDX_W = 2;
    localparam int LOW_BYTE_W = 8;

    typedef logic [WORD_W-1:0] word_t;

    // input command codes
    localparam logic CMD_ENCRYPT = 1'b0;
    localparam logic CMD_DECRYPT = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MODULUS     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PUBLIC_EXP  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PRIVATE_EXP = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_SQUARE,
        ST_MULT,
        ST_DONE
    } seq_state_t;

    // request to the serial modular multiplier
    typedef struct packed {
        logic  start;
        logic  wide;    // scan the full multiplier word, else its low WORD_W bits
        word_t a;       // multiplicand, below the modulus
    } mm_req_t;

    typedef struct packed {
        logic  done;
        word_t result;
    } mm_rsp_t;

endpackage

// ----- hdl/rsamx_modmul.sv -----
// Bit-serial interleaved modular multiplier: (a * x) mod m, one bit of x per cycle.
// Depends on rsamx_pkg.
`timescale 1ns / 1ps

module rsamx_modmul #(
    parameter int X_W = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  rsamx_pkg::mm_req_t     req_i,
    input  logic [X_W-1:0]         x_i,
    input  rsamx_pkg::word_t       modulus_i,
    output rsamx_pkg::mm_rsp_t     rsp_o
);
    import rsamx_pkg::*;

    localparam int CNT_W = $clog2(X_W + 1);
    localparam int T_W   = WORD_W + 2;

    word_t            r_reg, r_next;
    word_t            a_reg, a_next;
    logic [X_W-1:0]   x_reg, x_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    logic [T_W-1:0] t_sum;
    logic [T_W-1:0] m1;
    logic [T_W-1:0] m2;
    logic [T_W-1:0] t_red;

    assign m1 = {2'b00, modulus_i};
    assign m2 = {1'b0, modulus_i, 1'b0};

    // r stays below m, so 2r + a < 3m: one subtraction of 2m or m suffices
    always_comb begin
        t_sum = {1'b0, r_reg, 1'b0} + (x_reg[X_W-1] ? {2'b00, a_reg} : '0);
        if (t_sum >= m2) begin
            t_red = t_sum - m2;
        end else if (t_sum >= m1) begin
            t_red = t_sum - m1;
        end else begin
            t_red = t_sum;
        end
    end

    always_comb begin
        r_next    = r_reg;
        a_next    = a_reg;
        x_next    = x_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req_i.start) begin
            r_next    = '0;
            a_next    = req_i.a;
            busy_next = 1'b1;
            if (req_i.wide) begin
                x_next   = x_i;
                cnt_next = CNT_W'(X_W);
            end else begin
                // left-align the narrow operand so its MSB is scanned first
                x_next   = X_W'(x_i[WORD_W-1:0]) << (X_W - WORD_W);
                cnt_next = CNT_W'(WORD_W);
            end
        end else if (busy_reg) begin
            r_next   = t_red[WORD_W-1:0];
            x_next   = x_reg << 1;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        r_reg <= r_next;
        a_reg <= a_next;
        x_reg <= x_next;
    end

    assign rsp_o.done   = done_reg;
    assign rsp_o.result = r_reg;

endmodule

// ----- hdl/rsamx_seq.sv -----
// Square-and-multiply sequencer: walks the exponent MSB first and issues
// operations to the serial multiplier. Depends on rsamx_pkg.
`timescale 1ns / 1ps

module rsamx_seq #(
    parameter int X_W = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   start_i,
    input  logic                   cmd_i,
    input  logic [X_W-1:0]         value_i,
    input  rsamx_pkg::word_t       exponent_i,
    input  rsamx_pkg::word_t       modulus_i,
    output logic                   idle_o,
    output logic                   res_valid_o,
    input  logic                   res_ready_i,
    output rsamx_pkg::word_t       result_o,
    output rsamx_pkg::mm_req_t     mm_req_o,
    output logic [X_W-1:0]         mm_x_o,
    input  rsamx_pkg::mm_rsp_t     mm_rsp_i
);
    import rsamx_pkg::*;

    localparam int BIT_W = $clog2(WORD_W);

    seq_state_t       state_reg, state_next;
    logic             cmd_reg, cmd_next;
    word_t            exp_reg, exp_next;
    word_t            base_reg, base_next;
    word_t            acc_reg, acc_next;
    logic [BIT_W-1:0] bit_reg, bit_next;

    logic trivial;
    logic last_bit;

    // zero exponent gives 1; modulus of zero or one gives 0
    assign trivial  = (exponent_i == '0) || (modulus_i[WORD_W-1:1] == '0);
    assign last_bit = (bit_reg == BIT_W'(WORD_W - 1));

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (start_i) begin
                    state_next = trivial ? ST_DONE : ST_REDUCE;
                end
            end
            ST_REDUCE: begin
                if (mm_rsp_i.done) begin
                    state_next = ST_SQUARE;
                end
            end
            ST_SQUARE: begin
                if (mm_rsp_i.done) begin
                    if (exp_reg[WORD_W-1]) begin
                        state_next = ST_MULT;
                    end else begin
                        state_next = last_bit ? ST_DONE : ST_SQUARE;
                    end
                end
            end
            ST_MULT: begin
                if (mm_rsp_i.done) begin
                    state_next = last_bit ? ST_DONE : ST_SQUARE;
                end
            end
            ST_DONE: begin
                if (res_ready_i) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd_next  = cmd_reg;
        exp_next  = exp_reg;
        base_next = base_reg;
        acc_next  = acc_reg;
        bit_next  = bit_reg;
        mm_req_o  = '0;
        mm_x_o    = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (start_i) begin
                    cmd_next = cmd_i;
                    exp_next = exponent_i;
                    bit_next = '0;
                    if (exponent_i == '0) begin
                        acc_next = word_t'(1);
                    end else if (trivial) begin
                        acc_next = '0;
                    end else begin
                        // base mod m as 1 * value, scanning every value bit
                        mm_req_o.start = 1'b1;
                        mm_req_o.wide  = 1'b1;
                        mm_req_o.a     = word_t'(1);
                        mm_x_o         = value_i;
                    end
                end
            end
            ST_REDUCE: begin
                if (mm_rsp_i.done) begin
                    base_next      = mm_rsp_i.result;
                    acc_next       = word_t'(1);
                    mm_req_o.start = 1'b1;
                    mm_req_o.a     = word_t'(1);
                    mm_x_o         = X_W'(1);
                end
            end
            ST_SQUARE: begin
                if (mm_rsp_i.done) begin
                    acc_next = mm_rsp_i.result;
                    if (exp_reg[WORD_W-1]) begin
                        mm_req_o.start = 1'b1;
                        mm_req_o.a     = base_reg;
                        mm_x_o         = X_W'(mm_rsp_i.result);
                    end else begin
                        exp_next = exp_reg << 1;
                        bit_next = bit_reg + 1'b1;
                        if (!last_bit) begin
                            mm_req_o.start = 1'b1;
                            mm_req_o.a     = mm_rsp_i.result;
                            mm_x_o         = X_W'(mm_rsp_i.result);
                        end
                    end
                end
            end
            ST_MULT: begin
                if (mm_rsp_i.done) begin
                    acc_next = mm_rsp_i.result;
                    exp_next = exp_reg << 1;
                    bit_next = bit_reg + 1'b1;
                    if (!last_bit) begin
                        mm_req_o.start = 1'b1;
                        mm_req_o.a     = mm_rsp_i.result;
                        mm_x_o         = X_W'(mm_rsp_i.result);
                    end
                end
            end
            ST_DONE: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
        cmd_reg  <= cmd_next;
        exp_reg  <= exp_next;
        base_reg <= base_next;
        acc_reg  <= acc_next;
        bit_reg  <= bit_next;
    end

    assign idle_o      = (state_reg == ST_IDLE);
    assign res_valid_o = (state_reg == ST_DONE);
    // decrypt keeps only the low byte of the residue
    assign result_o    = (cmd_reg == CMD_DECRYPT)
                         ? word_t'(acc_reg[LOW_BYTE_W-1:0]) : acc_reg;

endmodule

// ----- hdl/rsa_modexp_cipher.sv -----
// Modular exponentiation engine: value^e mod n, bit-serial square-and-multiply.
// The value is first reduced mod n; then each of the 16 exponent bits takes a square,
// plus a multiply when the bit is set. Zero exponent or modulus <= 1 skips the multiplier.
// One item at a time; each square or multiply is a serial multiplier pass plus a handoff,
// and s_axis_tready returns as the result enters the output register.
// Reset (aresetn, synchronous, low): modulus 2, both exponents 1, engine idle.
`timescale 1ns / 1ps

module rsa_modexp_cipher #(
    parameter int VALUE_BITS = 16
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_wr_en,
    input  logic [rsamx_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  rsamx_pkg::word_t                      cfg_wdata,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [((VALUE_BITS+7)/8)*8-1:0]       s_axis_tdata,  // value
    input  logic [0:0]                            s_axis_tuser,  // cmd
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output rsamx_pkg::word_t                      m_axis_tdata   // result_value
);
    import rsamx_pkg::*;

    localparam int X_W = (VALUE_BITS > WORD_W) ? VALUE_BITS : WORD_W;

    word_t modulus_reg, modulus_next;
    word_t pub_exp_reg, pub_exp_next;
    word_t priv_exp_reg, priv_exp_next;
    logic  m_valid_reg, m_valid_next;
    word_t m_data_reg, m_data_next;

    logic           seq_start;
    logic           seq_idle;
    logic           res_valid;
    logic           res_load;
    word_t          res_value;
    word_t          exponent;
    logic [X_W-1:0] value_ext;
    mm_req_t        mm_req;
    mm_rsp_t        mm_rsp;
    logic [X_W-1:0] mm_x;

    always_comb begin
        modulus_next  = modulus_reg;
        pub_exp_next  = pub_exp_reg;
        priv_exp_next = priv_exp_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_MODULUS:     modulus_next  = cfg_wdata;
                REG_PUBLIC_EXP:  pub_exp_next  = cfg_wdata;
                REG_PRIVATE_EXP: priv_exp_next = cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    assign s_axis_tready = seq_idle;
    assign seq_start     = s_axis_tvalid && s_axis_tready;
    assign exponent      = (s_axis_tuser[0] == CMD_DECRYPT) ? priv_exp_reg : pub_exp_reg;
    assign value_ext     = X_W'(s_axis_tdata[VALUE_BITS-1:0]);

    // output register: result waits here while the engine takes the next transfer
    assign res_load = res_valid && (!m_valid_reg || m_axis_tready);

    always_comb begin
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg;
        if (res_load) begin
            m_data_next  = res_value;
            m_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            modulus_reg  <= word_t'(2);
            pub_exp_reg  <= word_t'(1);
            priv_exp_reg <= word_t'(1);
            m_valid_reg  <= 1'b0;
        end else begin
            modulus_reg  <= modulus_next;
            pub_exp_reg  <= pub_exp_next;
            priv_exp_reg <= priv_exp_next;
            m_valid_reg  <= m_valid_next;
        end
        m_data_reg <= m_data_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    rsamx_seq #(
        .X_W(X_W)
    ) u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start_i    (seq_start),
        .cmd_i      (s_axis_tuser[0]),
        .value_i    (value_ext),
        .exponent_i (exponent),
        .modulus_i  (modulus_reg),
        .idle_o     (seq_idle),
        .res_valid_o(res_valid),
        .res_ready_i(res_load),
        .result_o   (res_value),
        .mm_req_o   (mm_req),
        .mm_x_o     (mm_x),
        .mm_rsp_i   (mm_rsp)
    );

    rsamx_modmul #(
        .X_W(X_W)
    ) u_modmul (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req_i    (mm_req),
        .x_i      (mm_x),
        .modulus_i(modulus_reg),
        .rsp_o    (mm_rsp)
    );

endmodule
